>>> rtl/core/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants for the six-plane frustum culling test.
// ----------------------------------------------------------------------------
package fct_pkg;

    // Number of frustum planes held in configuration.
    localparam int PLANE_COUNT = 6;

    // Plane coefficients a, b and c are Q1.14, so d is scaled by 2^14.
    localparam int FRAC_BITS = 14;

    // Widths of the fields and of the configuration port.
    localparam int COORD_W    = 16;
    localparam int EXTENT_W   = 15;
    localparam int CMD_W      = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = $clog2(PLANE_COUNT);

    // Object kinds.
    localparam logic [CMD_W-1:0] CMD_POINT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CUBE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SPHERE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BOX    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_NEAR   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_FAR    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_LEFT   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_RIGHT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_TOP    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_BOTTOM = 3'd5;

    // One packed plane register.
    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] a;
    } t_plane;

    // Magnitude of a Q1.14 coefficient; the most negative code maps to 2^15.
    function automatic logic [COORD_W-1:0] coef_abs(input logic signed [COORD_W-1:0] v);
        coef_abs = v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
    endfunction

endpackage

>>> rtl/core/frustum_cull_test.sv
// ----------------------------------------------------------------------------
// frustum_cull_test
// Tests one point, cube, sphere or box per unstalled cycle against six frustum
// planes; reports whether it is visible. All arithmetic is exact fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  -------------------------------
//  object    in         i_valid / o_stall      i_cmd, i_center_*, i_extent_*
//  result    out        o_valid / i_stall      o_visible
//  config    in         i_cfg_wr_en            i_cfg_addr, i_cfg_wdata
//
//  One object enters per cycle while o_stall is low; each object passes through
//  the pipeline registers in order before its result can transfer out (input
//  register, products, sums, compare and merge).
//  The six planes are evaluated in six parallel lanes, each with six small
//  multipliers in the product stage, so without stalls it takes one object a cycle.
//  Synchronous active-low reset clears all valid bits and the planes to zero.
//  Each stage holds while the stage after it is full and held, so a stall on
//  the result side fills empty stages before it reaches o_stall.
//
module frustum_cull_test (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // object channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [fct_pkg::CMD_W-1:0]        i_cmd,
    input  logic signed [fct_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [fct_pkg::COORD_W-1:0] i_center_y,
    input  logic signed [fct_pkg::COORD_W-1:0] i_center_z,
    input  logic [fct_pkg::EXTENT_W-1:0]     i_extent_x,
    input  logic [fct_pkg::EXTENT_W-1:0]     i_extent_y,
    input  logic [fct_pkg::EXTENT_W-1:0]     i_extent_z,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_visible,
    // configuration port
    input  logic                             i_cfg_wr_en,
    input  logic [fct_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [fct_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import fct_pkg::*;

    localparam int PROD_W = 2 * COORD_W;              // a * x
    localparam int MAG_W  = COORD_W + EXTENT_W;       // |a| * e
    localparam int D_W    = COORD_W + FRAC_BITS;      // d * 2^14
    localparam int SUM_W  = PROD_W + 2;               // plane value
    localparam int MARG_W = MAG_W + 1;                // sum of three magnitudes
    localparam int CMP_W  = SUM_W + 1;                // plane value plus margin

    // Plane registers.
    t_plane [PLANE_COUNT-1:0] r_plane;

    // Stage valid bits and per-stage load enables.
    logic r_v0, r_v1, r_v2, r_v3;
    logic ld0, ld1, ld2, ld3;

    // Stage 0: registered object.
    logic [CMD_W-1:0]          r_cmd0;
    logic signed [COORD_W-1:0] r_cx0, r_cy0, r_cz0;
    logic [EXTENT_W-1:0]       r_ex0, r_ey0, r_ez0;

    // Stage 1: products per plane.
    logic [CMD_W-1:0]          r_cmd1;
    logic [EXTENT_W-1:0]       r_ex1;
    logic signed [PROD_W-1:0]  r_pa1 [PLANE_COUNT];
    logic signed [PROD_W-1:0]  r_pb1 [PLANE_COUNT];
    logic signed [PROD_W-1:0]  r_pc1 [PLANE_COUNT];
    logic signed [D_W-1:0]     r_pd1 [PLANE_COUNT];
    logic [MAG_W-1:0]          r_qa1 [PLANE_COUNT];
    logic [MAG_W-1:0]          r_qb1 [PLANE_COUNT];
    logic [MAG_W-1:0]          r_qc1 [PLANE_COUNT];
    logic signed [PROD_W-1:0]  n_pa1 [PLANE_COUNT];
    logic signed [PROD_W-1:0]  n_pb1 [PLANE_COUNT];
    logic signed [PROD_W-1:0]  n_pc1 [PLANE_COUNT];
    logic signed [D_W-1:0]     n_pd1 [PLANE_COUNT];
    logic [MAG_W-1:0]          n_qa1 [PLANE_COUNT];
    logic [MAG_W-1:0]          n_qb1 [PLANE_COUNT];
    logic [MAG_W-1:0]          n_qc1 [PLANE_COUNT];

    // Stage 2: plane value and box margin per plane.
    logic [CMD_W-1:0]          r_cmd2;
    logic [EXTENT_W-1:0]       r_ex2;
    logic signed [SUM_W-1:0]   r_s2 [PLANE_COUNT];
    logic [MARG_W-1:0]         r_m2 [PLANE_COUNT];
    logic signed [SUM_W-1:0]   n_s2 [PLANE_COUNT];
    logic [MARG_W-1:0]         n_m2 [PLANE_COUNT];

    // Stage 3: result register.
    logic                      r_vis3;
    logic                      n_vis3;

    // A stage loads when it is empty or its contents move on.
    assign ld3     = !r_v3 || !i_stall;
    assign ld2     = !r_v2 || ld3;
    assign ld1     = !r_v1 || ld2;
    assign ld0     = !r_v0 || ld1;
    assign o_stall = !ld0;
    assign o_valid = r_v3;
    assign o_visible = r_vis3;

    // Plane register writes; indexes beyond the last plane are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg_wr_en && (32'(i_cfg_addr) < PLANE_COUNT)) begin
            r_plane[i_cfg_addr] <= t_plane'(i_cfg_wdata);
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld0) r_v0 <= i_valid;
            if (ld1) r_v1 <= r_v0;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
        end
    end

    // Stage 0: capture the object; a cube uses its one half-size on all axes.
    always_ff @(posedge i_clk) begin
        if (ld0) begin
            r_cmd0 <= i_cmd;
            r_cx0  <= i_center_x;
            r_cy0  <= i_center_y;
            r_cz0  <= i_center_z;
            r_ex0  <= i_extent_x;
            r_ey0  <= (i_cmd == CMD_CUBE) ? i_extent_x : i_extent_y;
            r_ez0  <= (i_cmd == CMD_CUBE) ? i_extent_x : i_extent_z;
        end
    end

    // Stage 1: coefficient products and scaled offset for each plane.
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            n_pa1[p] = r_plane[p].a * r_cx0;
            n_pb1[p] = r_plane[p].b * r_cy0;
            n_pc1[p] = r_plane[p].c * r_cz0;
            n_pd1[p] = $signed({r_plane[p].d, {FRAC_BITS{1'b0}}});
            n_qa1[p] = coef_abs(r_plane[p].a) * r_ex0;
            n_qb1[p] = coef_abs(r_plane[p].b) * r_ey0;
            n_qc1[p] = coef_abs(r_plane[p].c) * r_ez0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_cmd1 <= r_cmd0;
            r_ex1  <= r_ex0;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_pa1[p] <= n_pa1[p];
                r_pb1[p] <= n_pb1[p];
                r_pc1[p] <= n_pc1[p];
                r_pd1[p] <= n_pd1[p];
                r_qa1[p] <= n_qa1[p];
                r_qb1[p] <= n_qb1[p];
                r_qc1[p] <= n_qc1[p];
            end
        end
    end

    // Stage 2: plane value at the centre and the farthest-corner margin.
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            n_s2[p] = SUM_W'(r_pa1[p]) + SUM_W'(r_pb1[p]) + SUM_W'(r_pc1[p])
                    + SUM_W'(r_pd1[p]);
            n_m2[p] = MARG_W'(r_qa1[p]) + MARG_W'(r_qb1[p]) + MARG_W'(r_qc1[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_cmd2 <= r_cmd1;
            r_ex2  <= r_ex1;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_s2[p] <= n_s2[p];
                r_m2[p] <= n_m2[p];
            end
        end
    end

    // Stage 3: a plane culls when value plus the mode's allowance is negative.
    always_comb begin
        logic signed [CMP_W-1:0] allow;
        logic signed [CMP_W-1:0] total;
        n_vis3 = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            unique case (r_cmd2)
                CMD_POINT:  allow = '0;
                CMD_SPHERE: allow = $signed({{(CMP_W-EXTENT_W-FRAC_BITS){1'b0}},
                                             r_ex2, {FRAC_BITS{1'b0}}});
                CMD_CUBE,
                CMD_BOX:    allow = $signed({{(CMP_W-MARG_W){1'b0}}, r_m2[p]});
                default:    allow = '0;
            endcase
            total = CMP_W'(r_s2[p]) + allow;
            if (total[CMP_W-1]) begin
                n_vis3 = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r_vis3 <= n_vis3;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // The object side is held only when every stage is occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v0 && r_v1 && r_v2 && r_v3))
        else $error("input held with an empty stage");

    // A sum that can move forward reaches the result register next cycle.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && ld3) |=> o_valid)
        else $error("item lost between sum and result stages");

    // Writes to indexes beyond the last plane leave the planes alone.
    a_bad_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wr_en && (32'(i_cfg_addr) >= PLANE_COUNT)) |=> $stable(r_plane))
        else $error("plane changed by an out-of-range write");

endmodule

>>> test/frustum_score_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_score_pkg
// Object record and visibility scoreboard for the frustum culling testbench.
// The scoreboard keeps its own copy of the six planes, predicts the visible
// bit of every object transfer and checks result transfers in order.
// ----------------------------------------------------------------------------
package frustum_score_pkg;

    import fct_pkg::*;

    // The plane distance is scaled by 2^14, so d is weighted by this.
    localparam longint PLANE_ONE = longint'(1) << FRAC_BITS;

    // One object as it crosses the input channel.
    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [EXTENT_W-1:0]       ex;
        logic [EXTENT_W-1:0]       ey;
        logic [EXTENT_W-1:0]       ez;
    } t_object;

    class visibility_scoreboard;

        t_plane planes[PLANE_COUNT];
        bit     expected_vis[$];
        int     mismatches;

        function new();
            foreach (planes[i]) planes[i] = '0;
            mismatches = 0;
        endfunction

        // Register writes above the last plane index are dropped by the block.
        function void load_plane(int unsigned idx, logic [CFG_DATA_W-1:0] value);
            if (idx < PLANE_COUNT) planes[idx] = t_plane'(value);
        endfunction

        // Exact six-plane test. Cubes and boxes only need the corner that lies
        // farthest along each plane normal.
        function bit predict_visible(t_object obj);
            longint x, y, z, rx, ry, rz;
            longint a, b, c, d, s, reach;
            bit     vis;
            x   = obj.cx;
            y   = obj.cy;
            z   = obj.cz;
            rx  = obj.ex;
            ry  = obj.ey;
            rz  = obj.ez;
            vis = 1'b1;
            if (obj.cmd == CMD_CUBE) begin
                ry = rx;
                rz = rx;
            end
            for (int i = 0; i < PLANE_COUNT; i++) begin
                a = planes[i].a;
                b = planes[i].b;
                c = planes[i].c;
                d = planes[i].d;
                s = a * x + b * y + c * z + d * PLANE_ONE;
                case (obj.cmd)
                    CMD_POINT: begin
                        if (s < 0) vis = 1'b0;
                    end
                    CMD_SPHERE: begin
                        // Touching the plane at exactly the radius still counts as visible.
                        if (s < -(rx * PLANE_ONE)) vis = 1'b0;
                    end
                    default: begin
                        reach = s + (a < 0 ? -a : a) * rx + (b < 0 ? -b : b) * ry
                                  + (c < 0 ? -c : c) * rz;
                        if (reach < 0) vis = 1'b0;
                    end
                endcase
            end
            return vis;
        endfunction

        function void note_object(t_object obj);
            expected_vis.push_back(predict_visible(obj));
        endfunction

        function void check_visible(logic actual);
            bit want;
            if (expected_vis.size() == 0) begin
                mismatches++;
                $error("visible: result transfer with nothing expected, actual %0b", actual);
                return;
            end
            want = expected_vis.pop_front();
            if (actual !== want) begin
                mismatches++;
                $error("visible mismatch: expected %0b, actual %0b", want, actual);
            end
        endfunction

        function int pending();
            return expected_vis.size();
        endfunction

    endclass

endpackage

>>> test/frustum_cull_test_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_test_test
// Self-checking testbench for the six-plane frustum culling block. It loads
// several plane sets (zero, directed boundaries, extremes, frustums, random),
// streams directed and random objects of all four kinds under varying idle
// and stall patterns, and compares every result against a scoreboard.
// ----------------------------------------------------------------------------
module frustum_cull_test_test;

    import fct_pkg::*;
    import frustum_score_pkg::*;

    // Indexes past the last plane; writes there must have no effect.
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [CMD_W-1:0]           i_cmd;
    logic signed [COORD_W-1:0]  i_center_x;
    logic signed [COORD_W-1:0]  i_center_y;
    logic signed [COORD_W-1:0]  i_center_z;
    logic [EXTENT_W-1:0]        i_extent_x;
    logic [EXTENT_W-1:0]        i_extent_y;
    logic [EXTENT_W-1:0]        i_extent_z;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic                       o_visible;
    logic                       i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0]      i_cfg_addr;
    logic [CFG_DATA_W-1:0]      i_cfg_wdata;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    visibility_scoreboard board;

    frustum_cull_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_center_z  (i_center_z),
        .i_extent_x  (i_extent_x),
        .i_extent_y  (i_extent_y),
        .i_extent_z  (i_extent_z),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_visible   (o_visible),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Random backpressure on the result channel.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic t_object make_obj(int cmd, int cx, int cy, int cz,
                                         int ex, int ey, int ez);
        t_object obj;
        obj.cmd = CMD_W'(cmd);
        obj.cx  = COORD_W'(cx);
        obj.cy  = COORD_W'(cy);
        obj.cz  = COORD_W'(cz);
        obj.ex  = EXTENT_W'(ex);
        obj.ey  = EXTENT_W'(ey);
        obj.ez  = EXTENT_W'(ez);
        return obj;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_plane(int a, int b, int c, int d);
        return {COORD_W'(d), COORD_W'(c), COORD_W'(b), COORD_W'(a)};
    endfunction

    // Mostly near the origin so the frustums give both outcomes, plus extremes.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(3))
            0, 1:    return COORD_W'($urandom_range(4000) - 2000);
            2:       return COORD_W'($urandom);
            default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    function automatic logic [EXTENT_W-1:0] rand_extent();
        case ($urandom_range(9))
            0:          return '1;
            1:          return '0;
            2, 3, 4, 5: return EXTENT_W'($urandom_range(2000));
            default:    return EXTENT_W'($urandom);
        endcase
    endfunction

    function automatic t_object rand_object();
        t_object obj;
        obj.cmd = CMD_W'($urandom_range(3));
        obj.cx  = rand_coord();
        obj.cy  = rand_coord();
        obj.cz  = rand_coord();
        obj.ex  = rand_extent();
        obj.ey  = rand_extent();
        obj.ez  = rand_extent();
        return obj;
    endfunction

    // A quarter of random planes are zero, which never cull.
    function automatic logic [CFG_DATA_W-1:0] rand_plane();
        logic [COORD_W-1:0] a, b, c, d;
        if ($urandom_range(3) == 0) return '0;
        a = $urandom_range(1) ? COORD_W'($urandom) : COORD_W'($urandom_range(32768) - 16384);
        b = $urandom_range(1) ? COORD_W'($urandom) : COORD_W'($urandom_range(32768) - 16384);
        c = $urandom_range(1) ? COORD_W'($urandom) : COORD_W'($urandom_range(32768) - 16384);
        d = $urandom_range(1) ? COORD_W'($urandom_range(4000) - 2000) : COORD_W'($urandom);
        return {d, c, b, a};
    endfunction

    // Leaves the write enable high so back-to-back writes need one assignment per edge.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        board.load_plane(idx, value);
    endtask

    task automatic write_planes(input logic [CFG_DATA_W-1:0] near_p, far_p, left_p,
                                right_p, top_p, bottom_p);
        write_reg(REG_PLANE_NEAR, near_p);
        write_reg(REG_PLANE_FAR, far_p);
        write_reg(REG_PLANE_LEFT, left_p);
        write_reg(REG_PLANE_RIGHT, right_p);
        write_reg(REG_PLANE_TOP, top_p);
        write_reg(REG_PLANE_BOTTOM, bottom_p);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Optional idle gap, then one object transfer.
    task automatic send_object(input t_object obj);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= obj.cmd;
        i_center_x <= obj.cx;
        i_center_y <= obj.cy;
        i_center_z <= obj.cz;
        i_extent_x <= obj.ex;
        i_extent_y <= obj.ey;
        i_extent_z <= obj.ez;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Check result transfers first, then note object transfers on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) board.check_visible(o_visible);
            if (i_valid && !o_stall) begin
                board.note_object(make_obj(i_cmd, i_center_x, i_center_y, i_center_z,
                                           i_extent_x, i_extent_y, i_extent_z));
            end
        end
    end

    // Watchdog: count cycles with work outstanding but no transfer on either side.
    always @(posedge i_clk) begin
        if (i_rst_n && (i_valid || board.pending() != 0)
                && !((i_valid && !o_stall) || (o_valid && !i_stall))) begin
            quiet_cycles++;
        end else begin
            quiet_cycles = 0;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_object directed[$];
        board = new();

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_cmd       <= CMD_POINT;
        i_center_x  <= '0;
        i_center_y  <= '0;
        i_center_z  <= '0;
        i_extent_x  <= '0;
        i_extent_y  <= '0;
        i_extent_z  <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_addr  <= REG_PLANE_NEAR;
        i_cfg_wdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Planes reset to zero, so everything is visible here.
        send_object(make_obj(CMD_POINT, -32768, -32768, -32768, 0, 0, 0));
        send_object(make_obj(CMD_SPHERE, 32767, -32768, 0, 32767, 0, 0));
        send_object(make_obj(CMD_CUBE, -32768, 0, 32767, 32767, 0, 0));
        send_object(make_obj(CMD_BOX, -32768, 32767, -32768, 32767, 32767, 32767));
        drain();

        // Directed boundaries: x >= 0, and y <= 50 through a most-negative coefficient.
        write_planes(pack_plane(16384, 0, 0, 0), pack_plane(0, -32768, 0, 100),
                     '0, '0, '0, '0);
        directed.push_back(make_obj(CMD_POINT, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_obj(CMD_POINT, -1, 0, 0, 0, 0, 0));
        directed.push_back(make_obj(CMD_POINT, 0, 50, 0, 0, 0, 0));
        directed.push_back(make_obj(CMD_POINT, 0, 51, 0, 0, 0, 0));
        directed.push_back(make_obj(CMD_POINT, 32767, -32768, 32767, 32767, 32767, 32767));
        directed.push_back(make_obj(CMD_POINT, -32768, 32767, -32768, 0, 0, 0));
        directed.push_back(make_obj(CMD_SPHERE, -100, 0, 0, 100, 0, 0));
        directed.push_back(make_obj(CMD_SPHERE, -101, 0, 0, 100, 32767, 32767));
        directed.push_back(make_obj(CMD_SPHERE, -32768, 0, 0, 32767, 0, 0));
        directed.push_back(make_obj(CMD_SPHERE, -32767, 0, 0, 32767, 0, 0));
        directed.push_back(make_obj(CMD_SPHERE, 0, -32768, 0, 0, 0, 0));
        directed.push_back(make_obj(CMD_CUBE, -7, 0, 0, 7, 0, 0));
        directed.push_back(make_obj(CMD_CUBE, -8, 0, 0, 7, 32767, 32767));
        directed.push_back(make_obj(CMD_CUBE, 0, 60, 0, 10, 0, 0));
        directed.push_back(make_obj(CMD_CUBE, 0, 60, 0, 9, 32767, 32767));
        directed.push_back(make_obj(CMD_BOX, 0, 60, 0, 0, 10, 0));
        directed.push_back(make_obj(CMD_BOX, 0, 60, 0, 0, 5, 0));
        directed.push_back(make_obj(CMD_BOX, -32768, 32767, -32768, 32767, 32767, 32767));
        directed.push_back(make_obj(CMD_BOX, -5, 0, 0, 4, 0, 0));
        directed.push_back(make_obj(CMD_BOX, 32767, -32768, 32767, 0, 0, 0));
        foreach (directed[i]) send_object(directed[i]);
        drain();

        // Random phases, each with its own plane set and idle pattern.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            case (ph)
                0: write_planes(pack_plane(0, 0, 16384, 1000), pack_plane(0, 0, -16384, 1000),
                                pack_plane(16384, 0, 0, 1000), pack_plane(-16384, 0, 0, 1000),
                                pack_plane(0, -16384, 0, 1000), pack_plane(0, 16384, 0, 1000));
                1: write_planes(pack_plane(32767, 32767, 32767, 32767),
                                pack_plane(32767, 32767, 32767, 32767),
                                pack_plane(32767, 32767, 32767, 32767),
                                pack_plane(32767, 32767, 32767, 32767),
                                pack_plane(32767, 32767, 32767, 32767),
                                pack_plane(32767, 32767, 32767, 32767));
                2: write_planes(pack_plane(-32768, -32768, -32768, -32768),
                                pack_plane(-32768, -32768, -32768, -32768),
                                pack_plane(-32768, -32768, -32768, -32768),
                                pack_plane(-32768, -32768, -32768, -32768),
                                pack_plane(-32768, -32768, -32768, -32768),
                                pack_plane(-32768, -32768, -32768, -32768));
                4: begin
                    // Writes past the last plane must leave every plane alone.
                    write_reg(REG_UNUSED_LO, {$urandom, $urandom});
                    write_reg(REG_UNUSED_HI, {$urandom, $urandom});
                    write_planes('0, '0, rand_plane(), rand_plane(), rand_plane(), rand_plane());
                end
                5: write_planes(pack_plane(0, 0, 16384, -10), pack_plane(0, 0, -16384, 3000),
                                pack_plane(11585, 0, 11585, 0), pack_plane(-11585, 0, 11585, 0),
                                pack_plane(0, -11585, 11585, 0), pack_plane(0, 11585, 11585, 0));
                default: write_planes(rand_plane(), rand_plane(), rand_plane(),
                                      rand_plane(), rand_plane(), rand_plane());
            endcase
            for (int n = 0; n < 100; n++) begin
                // Midway, hold off until the pipeline has emptied.
                if (n == 50) drain();
                send_object(rand_object());
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
